// File: rtl/core/rpdc_pkg.sv
// rpdc_pkg: shared types and constants for the rain pulse debounce counter
// holds the phase encoding and configuration register indexes
// no dependencies
`default_nettype none

package rpdc_pkg;

    // debounce sequencer phases
    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_QUIET  = 2'd1,
        PH_STABLE = 2'd2,
        PH_HOLD   = 2'd3
    } phase_t;

    // configuration port geometry
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned CFG_INDEX_W = 2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_QUIET_TICKS     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STABLE_TICKS    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DIAG_HOLD_TICKS = 2'd2;

    // register reset values
    localparam logic [CFG_DATA_W-1:0] QUIET_TICKS_RST     = 16'd50;
    localparam logic [CFG_DATA_W-1:0] STABLE_TICKS_RST    = 16'd20;
    localparam logic [CFG_DATA_W-1:0] DIAG_HOLD_TICKS_RST = 16'd5000;

    // pulse total width
    localparam int unsigned PULSE_W = 16;

endpackage

`default_nettype wire

// File: rtl/core/rain_pulse_debounce_counter.sv
// rain_pulse_debounce_counter: top level of the debounced rain gauge pulse counter
// depends on rpdc_pkg for the phase type, register indexes and reset values
//
// Usage:
//   Input channel (in_valid/in_ready/rain_contact) carries one beat per
//   1 ms tick with the sampled gauge contact level. Output channel
//   (out_valid/out_ready/indicator_on/pulse_count/diag_mode/pulse_counted)
//   returns one beat per input beat, in order.
//   The state update for a tick is done by the sequencer logic in the
//   accepting cycle and the result is held in the state and result
//   registers from the next edge on.
//   Throughput is one beat per cycle; the single result register limits
//   it, and in_ready stays high while that register is empty or being
//   drained in the same cycle.
//   If the receiver stalls, the result holds and in_ready drops until the
//   waiting beat is taken; the sequencer state does not advance meanwhile.
//   Reset puts the sequencer in its start phase with counter, pulse total,
//   diagnostic flag and lamp cleared and loads the register reset values
//   (quiet 50, stable 20, diagnostic hold 5000 ticks).
//   Configuration is written through cfg_wr_en/cfg_index/cfg_wdata; the user
//   keeps it to idle, unenforced by the block; unused-index writes are dropped.
`default_nettype none

module rain_pulse_debounce_counter #(
    parameter int unsigned COUNTER_WIDTH = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    input  wire logic                                cfg_wr_en,
    input  wire logic [rpdc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [rpdc_pkg::CFG_DATA_W-1:0]     cfg_wdata,

    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                rain_contact,

    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic                                     indicator_on,
    output logic [rpdc_pkg::PULSE_W-1:0]             pulse_count,
    output logic                                     diag_mode,
    output logic                                     pulse_counted
);

    // compare width covers both the counter and the 16-bit hold limit
    localparam int unsigned CMP_W = (COUNTER_WIDTH > rpdc_pkg::CFG_DATA_W) ?
                                    COUNTER_WIDTH : rpdc_pkg::CFG_DATA_W;
    localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = '1;

    // configuration registers
    logic [rpdc_pkg::CFG_DATA_W-1:0] quiet_ticks_reg;
    logic [rpdc_pkg::CFG_DATA_W-1:0] stable_ticks_reg;
    logic [rpdc_pkg::CFG_DATA_W-1:0] diag_hold_ticks_reg;

    // sequencer state and result registers
    rpdc_pkg::phase_t             phase_reg, phase_next;
    logic [COUNTER_WIDTH-1:0]     cnt_reg, cnt_next;
    logic [rpdc_pkg::PULSE_W-1:0] pulse_total_reg, pulse_total_next;
    logic                         diag_reg, diag_next;
    logic                         lamp_reg, lamp_next;
    logic                         counted_reg, counted_next;
    logic                         out_valid_reg;

    logic                         in_beat;
    logic [COUNTER_WIDTH-1:0]     quiet_load;
    logic [COUNTER_WIDTH-1:0]     stable_load;
    logic [CMP_W-1:0]             cnt_ext;
    logic [CMP_W-1:0]             diag_ext;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_ticks_reg     <= rpdc_pkg::QUIET_TICKS_RST;
            stable_ticks_reg    <= rpdc_pkg::STABLE_TICKS_RST;
            diag_hold_ticks_reg <= rpdc_pkg::DIAG_HOLD_TICKS_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                rpdc_pkg::REG_QUIET_TICKS:     quiet_ticks_reg     <= cfg_wdata;
                rpdc_pkg::REG_STABLE_TICKS:    stable_ticks_reg    <= cfg_wdata;
                rpdc_pkg::REG_DIAG_HOLD_TICKS: diag_hold_ticks_reg <= cfg_wdata;
                default:                       ;
            endcase
        end
    end

    // handshake: the result register is free or drains this cycle
    assign in_ready = !out_valid_reg || out_ready;
    assign in_beat  = in_valid && in_ready;

    // loaded times, fitted to the counter width
    assign quiet_load  = COUNTER_WIDTH'(CMP_W'(quiet_ticks_reg));
    assign stable_load = COUNTER_WIDTH'(CMP_W'(stable_ticks_reg));
    assign cnt_ext     = CMP_W'(cnt_reg);
    assign diag_ext    = CMP_W'(diag_hold_ticks_reg);

    // next state for one tick
    always_comb
    begin
        phase_next       = phase_reg;
        cnt_next         = cnt_reg;
        pulse_total_next = pulse_total_reg;
        diag_next        = diag_reg;
        lamp_next        = lamp_reg;
        counted_next     = 1'b0;
        case (phase_reg)
            rpdc_pkg::PH_START:
            begin
                cnt_next   = quiet_load;
                phase_next = rpdc_pkg::PH_QUIET;
            end
            rpdc_pkg::PH_QUIET:
            begin
                if (!rain_contact)
                begin
                    if (cnt_reg != '0)
                        cnt_next = cnt_reg - 1'b1;
                    else
                        lamp_next = 1'b0;
                end
                else if (cnt_reg == '0)
                begin
                    cnt_next   = stable_load;
                    phase_next = rpdc_pkg::PH_STABLE;
                end
                else
                begin
                    cnt_next = quiet_load;
                end
            end
            rpdc_pkg::PH_STABLE:
            begin
                if (rain_contact)
                begin
                    if (cnt_reg != '0)
                    begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                    else
                    begin
                        lamp_next  = 1'b1;
                        phase_next = rpdc_pkg::PH_HOLD;
                    end
                end
                else
                begin
                    cnt_next = stable_load;
                end
            end
            rpdc_pkg::PH_HOLD:
            begin
                if (rain_contact)
                begin
                    // hold length saturates
                    if (cnt_reg != CNT_MAX)
                        cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    if (cnt_ext > diag_ext)
                    begin
                        diag_next = 1'b1;
                    end
                    else
                    begin
                        pulse_total_next = pulse_total_reg + 1'b1;
                        counted_next     = 1'b1;
                    end
                    phase_next = rpdc_pkg::PH_START;
                end
            end
            default:
            begin
                phase_next = rpdc_pkg::PH_START;
            end
        endcase
    end

    // state and result registers advance only on an input beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= rpdc_pkg::PH_START;
            cnt_reg         <= '0;
            pulse_total_reg <= '0;
            diag_reg        <= 1'b0;
            lamp_reg        <= 1'b0;
            counted_reg     <= 1'b0;
        end
        else if (in_beat)
        begin
            phase_reg       <= phase_next;
            cnt_reg         <= cnt_next;
            pulse_total_reg <= pulse_total_next;
            diag_reg        <= diag_next;
            lamp_reg        <= lamp_next;
            counted_reg     <= counted_next;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_beat)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // result beat comes straight from the state registers
    assign out_valid     = out_valid_reg;
    assign indicator_on  = lamp_reg;
    assign pulse_count   = pulse_total_reg;
    assign diag_mode     = diag_reg;
    assign pulse_counted = counted_reg;

    // lamp is lit for the whole hold
    a_hold_lamp_on: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == rpdc_pkg::PH_HOLD |-> lamp_reg)
        else $error("hold phase with lamp off");

    // a counted pulse is reported with the lamp still lit
    a_count_lamp: assert property (@(posedge clk) disable iff (!rst_n)
        counted_reg |-> lamp_reg && phase_reg == rpdc_pkg::PH_START)
        else $error("pulse counted outside a confirmed hold");

    // diagnostic flag is sticky
    a_diag_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        diag_reg |=> diag_reg)
        else $error("diagnostic flag cleared");

    // the pulse total moves only with a reported count
    a_total_moves: assert property (@(posedge clk) disable iff (!rst_n)
        pulse_total_reg != $past(pulse_total_reg) |-> counted_reg && out_valid_reg)
        else $error("pulse total changed without a counted beat");

    // state holds while the result beat is stalled
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> $stable(phase_reg) && $stable(cnt_reg))
        else $error("sequencer advanced under a stalled result");

endmodule

`default_nettype wire

// File: bench/rain_pulse_debounce_counter_test.sv
// rain_pulse_debounce_counter_test: self-checking bench for the rain pulse debounce counter
// drives tick beats and register writes, predicts every result beat and compares in order
// depends on rpdc_pkg and rain_pulse_debounce_counter
`default_nettype none

module rain_pulse_debounce_counter_test;

    localparam int unsigned TICK_CNT_W = 16;
    localparam logic [rpdc_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    // one result beat as the block reports it
    typedef struct packed {
        logic                         lamp;
        logic [rpdc_pkg::PULSE_W-1:0] count;
        logic                         diag;
        logic                         counted;
    } gauge_reading_t;

    localparam gauge_reading_t ALL_CLEAR = '0;

    typedef enum bit {ROW_TICK, ROW_WRITE} row_kind_t;

    // one line of the opening table: a tick beat or a register write
    typedef struct packed {
        row_kind_t                            kind;
        logic [rpdc_pkg::CFG_INDEX_W-1:0]     idx;
        logic [rpdc_pkg::CFG_DATA_W-1:0]      val;
        logic                                 contact;
        logic                                 typed;
        gauge_reading_t                       want;
    } opening_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [rpdc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [rpdc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic rain_contact = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic indicator_on;
    logic [rpdc_pkg::PULSE_W-1:0] pulse_count;
    logic diag_mode;
    logic pulse_counted;

    // predictor state and register copies
    rpdc_pkg::phase_t gauge_phase;
    logic [TICK_CNT_W-1:0] gauge_cnt;
    logic [rpdc_pkg::PULSE_W-1:0] pulse_total_q;
    logic diag_q;
    logic lamp_q;
    logic [rpdc_pkg::CFG_DATA_W-1:0] quiet_r;
    logic [rpdc_pkg::CFG_DATA_W-1:0] stable_r;
    logic [rpdc_pkg::CFG_DATA_W-1:0] diag_r;

    gauge_reading_t pending_readings[$];
    gauge_reading_t want_reading;
    gauge_reading_t seen_reading;
    int mismatch_count = 0;
    int ticks_sent = 0;
    bit bus_calm = 1'b0;
    bit hold_off_req = 1'b0;

    opening_row_t opening_rows [26];

    rain_pulse_debounce_counter uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rain_contact  (rain_contact),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .indicator_on  (indicator_on),
        .pulse_count   (pulse_count),
        .diag_mode     (diag_mode),
        .pulse_counted (pulse_counted)
    );

    always #2 clk = ~clk;

    // advance the debounce sequencer by one tick and return the reading
    function automatic gauge_reading_t gauge_step(input logic closed);
        gauge_reading_t r;
        r.counted = 1'b0;
        case (gauge_phase)
            rpdc_pkg::PH_START:
            begin
                gauge_cnt   = TICK_CNT_W'(quiet_r);
                gauge_phase = rpdc_pkg::PH_QUIET;
            end
            rpdc_pkg::PH_QUIET:
            begin
                if (!closed)
                begin
                    if (gauge_cnt != '0)
                        gauge_cnt = gauge_cnt - 1'b1;
                    else
                        lamp_q = 1'b0;
                end
                else if (gauge_cnt == '0)
                begin
                    gauge_cnt   = TICK_CNT_W'(stable_r);
                    gauge_phase = rpdc_pkg::PH_STABLE;
                end
                else
                    gauge_cnt = TICK_CNT_W'(quiet_r);
            end
            rpdc_pkg::PH_STABLE:
            begin
                if (closed)
                begin
                    if (gauge_cnt != '0)
                        gauge_cnt = gauge_cnt - 1'b1;
                    else
                    begin
                        lamp_q      = 1'b1;
                        gauge_phase = rpdc_pkg::PH_HOLD;
                    end
                end
                else
                    gauge_cnt = TICK_CNT_W'(stable_r);
            end
            default:
            begin
                // hold length saturates, release decides count or diagnostic
                if (closed)
                begin
                    if (gauge_cnt != '1)
                        gauge_cnt = gauge_cnt + 1'b1;
                end
                else
                begin
                    if (gauge_cnt > diag_r)
                        diag_q = 1'b1;
                    else
                    begin
                        pulse_total_q = pulse_total_q + 1'b1;
                        r.counted     = 1'b1;
                    end
                    gauge_phase = rpdc_pkg::PH_START;
                end
            end
        endcase
        r.lamp  = lamp_q;
        r.count = pulse_total_q;
        r.diag  = diag_q;
        return r;
    endfunction

    // offer one tick beat, with random idle cycles ahead of it
    task automatic send_tick(input logic closed);
        while (!bus_calm && $urandom_range(99) < 14)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        rain_contact <= closed;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_readings.push_back(gauge_step(closed));
        ticks_sent++;
    endtask

    // register write once every pending reading has come back
    task automatic write_reg(input logic [rpdc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [rpdc_pkg::CFG_DATA_W-1:0] val);
        in_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            rpdc_pkg::REG_QUIET_TICKS:     quiet_r = val;
            rpdc_pkg::REG_STABLE_TICKS:    stable_r = val;
            rpdc_pkg::REG_DIAG_HOLD_TICKS: diag_r = val;
            default: ;
        endcase
    endtask

    // one rain pulse shaped around the current times, with bounces now and then
    task automatic send_episode();
        int open_len;
        int close_len;
        open_len = quiet_r + $urandom_range(2);
        if ($urandom_range(3) == 0)
        begin
            repeat ($urandom_range(quiet_r)) send_tick(1'b0);
            send_tick(1'b1);
        end
        repeat (open_len) send_tick(1'b0);
        if ($urandom_range(4) == 0)
        begin
            repeat ($urandom_range(stable_r)) send_tick(1'b1);
            send_tick(1'b0);
        end
        close_len = stable_r + 1 + $urandom_range(diag_r + 3);
        repeat (close_len) send_tick(1'b1);
        send_tick(1'b0);
    endtask

    // mostly well-formed pulses, the rest random contact noise
    task automatic run_random_phase(input int n_ticks);
        int first;
        first = ticks_sent;
        while (ticks_sent - first < n_ticks)
        begin
            if ($urandom_range(7) == 0)
                repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(1)));
            else
                send_episode();
        end
    endtask

    // result sink: random stalls, a long hold-off on request
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall_left   = 200;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= bus_calm || ($urandom_range(99) >= 14);
        end
    end

    // in-order check of every accepted result beat
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen_reading = {indicator_on, pulse_count, diag_mode, pulse_counted};
            if (pending_readings.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display({"%0t: result beat with nothing pending: ",
                              "lamp=%0b count=%0d diag=%0b counted=%0b"},
                             $time, seen_reading.lamp, seen_reading.count,
                             seen_reading.diag, seen_reading.counted);
            end
            else
            begin
                want_reading = pending_readings.pop_front();
                if (seen_reading.lamp !== want_reading.lamp ||
                    seen_reading.count !== want_reading.count ||
                    seen_reading.diag !== want_reading.diag ||
                    seen_reading.counted !== want_reading.counted)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"%0t: expected lamp=%0b count=%0d diag=%0b counted=%0b, ",
                                  "got lamp=%0b count=%0d diag=%0b counted=%0b"},
                                 $time, want_reading.lamp, want_reading.count,
                                 want_reading.diag, want_reading.counted,
                                 seen_reading.lamp, seen_reading.count,
                                 seen_reading.diag, seen_reading.counted);
                end
            end
        end
    end

    initial
    begin : watchdog
        #400_000;
        $display("rain_pulse_debounce_counter_test: FAIL");
        $finish;
    end

    initial
    begin : stimulus
        int r;
        int p;

        // opening table: kind, index, data, contact, typed, expected reading
        opening_rows = '{
            // start phase right after reset, then early contact reloads the quiet time
            '{ROW_TICK,  rpdc_pkg::REG_QUIET_TICKS,     16'd0,    1'b0, 1'b1, ALL_CLEAR},
            '{ROW_TICK,  rpdc_pkg::REG_QUIET_TICKS,     16'd0,    1'b1, 1'b1, ALL_CLEAR},
            '{ROW_TICK,  rpdc_pkg::REG_QUIET_TICKS,     16'd0,    1'b0, 1'b1, ALL_CLEAR},
            '{ROW_WRITE, rpdc_pkg::REG_QUIET_TICKS,     16'd0,    1'b0, 1'b0, ALL_CLEAR},
            '{ROW_WRITE, rpdc_pkg::REG_STABLE_TICKS,    16'd1,    1'b0, 1'b0, ALL_CLEAR},
            '{ROW_WRITE, rpdc_pkg::REG_DIAG_HOLD_TICKS, 16'd2,    1'b0, 1'b0, ALL_CLEAR},
            // reload to zero quiet time, then into the stable wait with one break
            '{ROW_TICK,  rpdc_pkg::REG_QUIET_TICKS,     16'd0,    1'b1, 1'b0, ALL_CLEAR},
            '{ROW_TICK,  rpdc_pkg::REG_QUIET_TICKS,     16'd0,    1'b1, 1'b0, ALL_CLEAR},
            '{ROW_TICK,  rpdc_pkg::REG_QUIET_TICKS,     16'd0,    1'b0, 1'b0, ALL_CLEAR},
            '{ROW_TICK,  rpdc_pkg::REG_QUIET_TICKS,     16'd0,    1'b1, 1'b0, ALL_CLEAR},
            '{ROW_TICK,  rpdc_pkg::REG_QUIET_TICKS,     16'd0,    1'b1, 1'b1,
              {1'b1, 16'd0, 1'b0, 1'b0}},
            // hold equal to the diagnostic time still counts
            '{ROW_TICK,  rpdc_pkg::REG_QUIET_TICKS,     16'd0,    1'b1, 1'b0, ALL_CLEAR},
            '{ROW_TICK,  rpdc_pkg::REG_QUIET_TICKS,     16'd0,    1'b1, 1'b0, ALL_CLEAR},
            '{ROW_TICK,  rpdc_pkg::REG_QUIET_TICKS,     16'd0,    1'b0, 1'b1,
              {1'b1, 16'd1, 1'b0, 1'b1}},
            '{ROW_TICK,  rpdc_pkg::REG_QUIET_TICKS,     16'd0,    1'b1, 1'b0, ALL_CLEAR},
            '{ROW_TICK,  rpdc_pkg::REG_QUIET_TICKS,     16'd0,    1'b0, 1'b1,
              {1'b0, 16'd1, 1'b0, 1'b0}},
            // second pulse held one tick too long sets the diagnostic flag
            '{ROW_TICK,  rpdc_pkg::REG_QUIET_TICKS,     16'd0,    1'b1, 1'b0, ALL_CLEAR},
            '{ROW_TICK,  rpdc_pkg::REG_QUIET_TICKS,     16'd0,    1'b1, 1'b0, ALL_CLEAR},
            '{ROW_TICK,  rpdc_pkg::REG_QUIET_TICKS,     16'd0,    1'b1, 1'b0, ALL_CLEAR},
            '{ROW_TICK,  rpdc_pkg::REG_QUIET_TICKS,     16'd0,    1'b1, 1'b0, ALL_CLEAR},
            '{ROW_TICK,  rpdc_pkg::REG_QUIET_TICKS,     16'd0,    1'b1, 1'b0, ALL_CLEAR},
            '{ROW_TICK,  rpdc_pkg::REG_QUIET_TICKS,     16'd0,    1'b1, 1'b0, ALL_CLEAR},
            '{ROW_TICK,  rpdc_pkg::REG_QUIET_TICKS,     16'd0,    1'b0, 1'b1,
              {1'b1, 16'd1, 1'b1, 1'b0}},
            // write to the unused index must leave the quiet time alone
            '{ROW_WRITE, REG_UNUSED,                    16'hFFFF, 1'b0, 1'b0, ALL_CLEAR},
            '{ROW_TICK,  rpdc_pkg::REG_QUIET_TICKS,     16'd0,    1'b0, 1'b0, ALL_CLEAR},
            '{ROW_TICK,  rpdc_pkg::REG_QUIET_TICKS,     16'd0,    1'b1, 1'b0, ALL_CLEAR}
        };

        // predictor reset state
        gauge_phase   = rpdc_pkg::PH_START;
        gauge_cnt     = '0;
        pulse_total_q = '0;
        diag_q        = 1'b0;
        lamp_q        = 1'b0;
        quiet_r       = rpdc_pkg::QUIET_TICKS_RST;
        stable_r      = rpdc_pkg::STABLE_TICKS_RST;
        diag_r        = rpdc_pkg::DIAG_HOLD_TICKS_RST;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // opening table
        for (r = 0; r < 26; r++)
        begin
            if (opening_rows[r].kind == ROW_WRITE)
                write_reg(opening_rows[r].idx, opening_rows[r].val);
            else
            begin
                send_tick(opening_rows[r].contact);
                // typed rows replace the prediction just queued
                if (opening_rows[r].typed)
                    pending_readings[pending_readings.size() - 1] = opening_rows[r].want;
            end
        end

        // random phases over short times, zero times and zero diagnostic first
        for (p = 0; p < 6; p++)
        begin
            write_reg(rpdc_pkg::REG_QUIET_TICKS,
                      (p == 0) ? 16'd0 : 16'($urandom_range(4)));
            write_reg(rpdc_pkg::REG_STABLE_TICKS,
                      (p == 0) ? 16'd0 : 16'($urandom_range(4)));
            write_reg(rpdc_pkg::REG_DIAG_HOLD_TICKS,
                      (p == 0) ? 16'd0 : 16'($urandom_range(12)));
            if (p == 2)
                hold_off_req = 1'b1;
            // one phase runs with no idling on either side
            bus_calm = (p == 4);
            run_random_phase(90);
        end
        bus_calm = 1'b0;

        // widest quiet time: contact reloads it, open ticks count it down
        write_reg(rpdc_pkg::REG_QUIET_TICKS, 16'hFFFF);
        write_reg(rpdc_pkg::REG_DIAG_HOLD_TICKS, 16'd65534);
        repeat (4) send_tick(1'b0);
        send_tick(1'b1);
        repeat (3) send_tick(1'b0);

        // widest stable time
        write_reg(rpdc_pkg::REG_QUIET_TICKS, 16'd0);
        write_reg(rpdc_pkg::REG_STABLE_TICKS, 16'hFFFF);
        repeat (3) send_tick(1'b0);
        repeat (4) send_tick(1'b1);
        send_tick(1'b0);
        repeat (2) send_tick(1'b1);

        // short random tail
        write_reg(rpdc_pkg::REG_QUIET_TICKS, 16'd2);
        write_reg(rpdc_pkg::REG_STABLE_TICKS, 16'd1);
        write_reg(rpdc_pkg::REG_DIAG_HOLD_TICKS, 16'd6);
        run_random_phase(30);

        // drain and finish
        in_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && pending_readings.size() == 0)
            $display("rain_pulse_debounce_counter_test: PASS");
        else
            $display("rain_pulse_debounce_counter_test: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
